>>> hw/rtl/fpsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpsa_pkg
// Shared constants, codes and types of the free page stack allocator.
// ----------------------------------------------------------------------------
package fpsa_pkg;

  // store geometry
  localparam int STORE_DEPTH  = 131072;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);
  localparam int CNT_W        = $clog2(STORE_DEPTH + 1);

  // field widths
  localparam int BYTE_ADDR_W  = 32;
  localparam int KIND_W       = 2;
  localparam int STATUS_W     = 2;
  localparam int FREE_COUNT_W = 18;
  localparam int PAGE_SHIFT   = 12;
  localparam int PAGE_W       = BYTE_ADDR_W - PAGE_SHIFT;
  localparam int PG_W         = PAGE_W + 1;   // page number that may reach the top of space

  // command queue between front and back
  localparam int QDEPTH       = 2;
  localparam int QPTR_W       = $clog2(QDEPTH);
  localparam int QCNT_W       = $clog2(QDEPTH + 1);

  // item kinds
  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FREE  = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_LOAD,
    OP_ALLOC,
    OP_FREE
  } op_t;

  // classified command: pg is the first page of a load or the freed page,
  // a load covers pages p with p < ep, or p == ep when frac is set
  typedef struct packed {
    op_t             op;
    logic [PG_W-1:0] pg;
    logic [PG_W-1:0] ep;
    logic            frac;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

endpackage

>>> hw/rtl/fpsa_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpsa channel interfaces
// Valid/ready channels for requests and results of the page allocator.
// ----------------------------------------------------------------------------
interface fpsa_in_if import fpsa_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [KIND_W-1:0]      kind;
  logic [BYTE_ADDR_W-1:0] region_base;
  logic [BYTE_ADDR_W-1:0] region_length;
  logic                   region_available;
  logic [BYTE_ADDR_W-1:0] freed_address;

  modport source (output valid, kind, region_base, region_length, region_available,
                  freed_address, input ready);
  modport sink   (input valid, kind, region_base, region_length, region_available,
                  freed_address, output ready);
endinterface

interface fpsa_out_if import fpsa_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [BYTE_ADDR_W-1:0]  page_address;
  logic [STATUS_W-1:0]     status;
  logic [FREE_COUNT_W-1:0] free_count;

  modport source (output valid, page_address, status, free_count, input ready);
  modport sink   (input valid, page_address, status, free_count, output ready);
endinterface

>>> hw/rtl/fpsa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpsa_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module fpsa_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

>>> hw/rtl/fpsa_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpsa_front
// Accepts request transactions and turns them into page-number commands.
// ----------------------------------------------------------------------------
module fpsa_front import fpsa_pkg::*; (
  fpsa_in_if.sink in_ch,
  input  q_stat_t q_stat,
  output logic    push,
  output cmd_t    cmd
);

  logic [BYTE_ADDR_W:0] end_sum;

  assign in_ch.ready = !q_stat.full;
  assign push        = in_ch.valid && !q_stat.full;

  // end of region, one bit wider so a wrap shows as saturation
  assign end_sum = {1'b0, in_ch.region_base} + {1'b0, in_ch.region_length};

  always_comb begin
    cmd.op   = OP_NOP;
    cmd.pg   = {1'b0, in_ch.freed_address[BYTE_ADDR_W-1:PAGE_SHIFT]};
    cmd.ep   = '0;
    cmd.frac = 1'b0;
    case (in_ch.kind)
      KIND_LOAD: begin
        if (in_ch.region_available) begin
          cmd.op = OP_LOAD;
          // base rounded up to a page
          cmd.pg = {1'b0, in_ch.region_base[BYTE_ADDR_W-1:PAGE_SHIFT]} +
                   PG_W'(|in_ch.region_base[PAGE_SHIFT-1:0]);
          if (end_sum[BYTE_ADDR_W]) begin
            cmd.ep   = PG_W'(1) << PAGE_W;
            cmd.frac = 1'b0;
          end else begin
            cmd.ep   = {1'b0, end_sum[BYTE_ADDR_W-1:PAGE_SHIFT]};
            cmd.frac = |end_sum[PAGE_SHIFT-1:0];
          end
        end
      end
      KIND_ALLOC: cmd.op = OP_ALLOC;
      KIND_FREE:  cmd.op = OP_FREE;
      default:    cmd.op = OP_NOP;
    endcase
  end

endmodule

>>> hw/rtl/fpsa_cmd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpsa_cmd_queue
// Small command FIFO that decouples the front from the back.
// ----------------------------------------------------------------------------
module fpsa_cmd_queue import fpsa_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    cmd_in,
  input  logic    pop,
  output cmd_t    cmd_out,
  output q_stat_t q_stat
);

  cmd_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, wp_nxt;
  logic [QPTR_W-1:0] rp_r, rp_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign q_stat.valid = cnt_r != '0;
  assign q_stat.full  = cnt_r == QCNT_W'(QDEPTH);
  assign cmd_out      = q_r[rp_r];

  assign do_push = push && !q_stat.full;
  assign do_pop  = pop && q_stat.valid;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == QPTR_W'(QDEPTH - 1)) ? '0 : wp_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rp_nxt = (rp_r == QPTR_W'(QDEPTH - 1)) ? '0 : rp_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wp_r] <= cmd_in;
    end
  end

endmodule

>>> hw/rtl/fpsa_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpsa_back
// Executes commands against the page stack and registers each result.
// ----------------------------------------------------------------------------
module fpsa_back import fpsa_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  q_stat_t q_stat,
  input  cmd_t    q_cmd,
  output logic    pop,
  fpsa_out_if.source out_ch
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LOAD = 3'b010,
    S_READ = 3'b100
  } bstate_t;

  bstate_t                 state_r, state_nxt;
  logic [CNT_W-1:0]        top_r, top_nxt;
  logic [PG_W-1:0]         cur_r, cur_nxt;
  logic [PG_W-1:0]         ep_r, ep_nxt;
  logic                    frac_r, frac_nxt;

  logic                    out_valid_r;
  logic [BYTE_ADDR_W-1:0]  out_addr_r;
  logic [STATUS_W-1:0]     out_status_r;
  logic [FREE_COUNT_W-1:0] out_count_r;

  logic                    out_free;
  logic                    emit;
  logic [BYTE_ADDR_W-1:0]  e_addr;
  logic [STATUS_W-1:0]     e_status;
  logic                    more, full, empty;
  logic [CNT_W-1:0]        top_dec;

  logic                    ram_en, ram_we;
  logic [ADDR_W-1:0]       ram_addr;
  logic [PAGE_W-1:0]       ram_wdata, ram_rdata;

  fpsa_ram #(
    .WIDTH (PAGE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign out_free = !out_valid_r || out_ch.ready;
  assign full     = top_r == CNT_W'(STORE_DEPTH);
  assign empty    = top_r == '0;
  assign top_dec  = top_r - CNT_W'(1);
  assign more     = (cur_r < ep_r) || ((cur_r == ep_r) && frac_r);

  always_comb begin
    state_nxt = state_r;
    top_nxt   = top_r;
    cur_nxt   = cur_r;
    ep_nxt    = ep_r;
    frac_nxt  = frac_r;
    pop       = 1'b0;
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = top_r[ADDR_W-1:0];
    ram_wdata = cur_r[PAGE_W-1:0];
    emit      = 1'b0;
    e_addr    = '0;
    e_status  = ST_OK;
    case (state_r)
      S_IDLE: begin
        if (q_stat.valid && out_free) begin
          pop = 1'b1;
          case (q_cmd.op)
            OP_FREE: begin
              emit = 1'b1;
              if (full) begin
                e_status = ST_FULL;
              end else begin
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_wdata = q_cmd.pg[PAGE_W-1:0];
                top_nxt   = top_r + CNT_W'(1);
              end
            end
            OP_ALLOC: begin
              if (empty) begin
                emit     = 1'b1;
                e_status = ST_EMPTY;
              end else begin
                ram_en    = 1'b1;
                ram_addr  = top_dec[ADDR_W-1:0];
                top_nxt   = top_dec;
                state_nxt = S_READ;
              end
            end
            OP_LOAD: begin
              cur_nxt   = q_cmd.pg;
              ep_nxt    = q_cmd.ep;
              frac_nxt  = q_cmd.frac;
              state_nxt = S_LOAD;
            end
            default: emit = 1'b1;
          endcase
        end
      end
      S_LOAD: begin
        if (!more) begin
          if (out_free) begin
            emit      = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (full) begin
          if (out_free) begin
            emit      = 1'b1;
            e_status  = ST_FULL;
            state_nxt = S_IDLE;
          end
        end else begin
          ram_en  = 1'b1;
          ram_we  = 1'b1;
          top_nxt = top_r + CNT_W'(1);
          cur_nxt = cur_r + PG_W'(1);
        end
      end
      S_READ: begin
        if (out_free) begin
          emit      = 1'b1;
          e_addr    = {ram_rdata, PAGE_SHIFT'(0)};
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      top_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      top_r   <= top_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    ep_r   <= ep_nxt;
    frac_r <= frac_nxt;
    if (emit) begin
      out_addr_r   <= e_addr;
      out_status_r <= e_status;
      out_count_r  <= FREE_COUNT_W'(top_nxt);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.page_address = out_addr_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.free_count   = out_count_r;

  // stack never grows past the store
  a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= CNT_W'(STORE_DEPTH))
    else $error("stack top past store depth");

  // a full status is only reported with the stack full
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    emit && e_status == ST_FULL |-> full)
    else $error("full status with room in the stack");

  // no write into the store once it is full
  a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
    ram_en && ram_we |-> !full)
    else $error("store write while full");

  // a successful allocate pops exactly one page and waits for read data
  a_alloc_pop: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE && pop && q_cmd.op == OP_ALLOC && !empty
    |=> state_r == S_READ && top_r == $past(top_r) - CNT_W'(1))
    else $error("allocate did not pop one page");

  // results are never overwritten while held
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> out_free)
    else $error("result register overwritten");

endmodule

>>> hw/rtl/free_page_stack_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_page_stack_allocator_unit
// Hardware stack of free 4 KiB page numbers with region load, allocate, free.
// ----------------------------------------------------------------------------
// Every request transaction yields exactly one result transaction, in order.
// A region load with the available flag set rounds its base up to 4 KiB and
// pushes each page that starts below base plus length (end saturates at 4 GiB);
// if the store fills, the remaining pages are dropped and status 2 is reported.
// An allocate pops the last pushed page (status 1 and address 0 when empty);
// a free pushes the page of freed_address, ignoring its low 12 bits (status 2
// and the page dropped when full). Unavailable regions and kind 3 report ok.
// The front takes a request whenever its two-entry command queue has room,
// so requests stream in while the back is busy. The back runs one command
// at a time on a single-port page store: free and ignored items finish in
// the idle state, an allocate adds a read state for the registered store
// read, and a load is set up in idle, then pushes its pages and reports in
// the load state. The store is never cleared: only entries below top are read.
// ----------------------------------------------------------------------------
module free_page_stack_allocator_unit import fpsa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  fpsa_in_if.sink     in_ch,
  fpsa_out_if.source  out_ch
);

  // front to queue
  logic    push;
  cmd_t    cmd_in;

  // queue to back
  cmd_t    cmd_out;
  logic    pop;
  q_stat_t q_stat;

  // request decode: page-align the region and classify the transaction
  fpsa_front u_front (
    .in_ch  (in_ch),
    .q_stat (q_stat),
    .push   (push),
    .cmd    (cmd_in)
  );

  // decoupling queue, lets the front keep accepting while a load runs
  fpsa_cmd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .cmd_in  (cmd_in),
    .pop     (pop),
    .cmd_out (cmd_out),
    .q_stat  (q_stat)
  );

  // stack engine with the page store and the result register
  fpsa_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_stat (q_stat),
    .q_cmd  (cmd_out),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
